// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre must always be followed in the same cycle by con
`define ASSERT_IMPLY(lbl, clk, rstn, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (con)) \
    else $error("implication check failed");

// cond must never hold
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: sv/kce_pkg.sv
package kce_pkg;

  typedef enum logic {
    KIND_SCAN = 1'b0,
    KIND_LOAD = 1'b1
  } kind_e;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // queue entry between front and back
  typedef struct packed {
    kind_e       kind;
    logic [31:0] keys;
    logic [31:0] diff;
    logic [3:0]  idx;
    logic [4:0]  sc;
    logic [9:0]  kc;
  } qent_t;

  // one result event, scancode in the low bits
  typedef struct packed {
    logic       sync;
    logic       mapped;
    logic       pressed;
    logic [9:0] keycode;
    logic [4:0] scancode;
  } evt_t;

  // one-hot to binary
  function automatic logic [4:0] onehot_idx(input logic [31:0] oh);
    logic [4:0] r;
    r = '0;
    for (int b = 0; b < 32; b++) begin
      if (oh[b]) begin
        r = r | 5'(b);
      end
    end
    return r;
  endfunction

endpackage

// File: sv/kce_ram.sv
module kce_ram #(
  parameter int unsigned WIDTH = 15,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/kce_front.sv
module kce_front #(
  parameter int unsigned KEYMAP_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_op_i,
  input  logic [55:0]         in_data_i,
  input  logic                full_i,
  output logic                push_o,
  output kce_pkg::qent_t      push_data_o
);

  localparam logic [6:0] DEPTH7 = 7'(KEYMAP_DEPTH);

  logic [31:0] prev_q, prev_d;
  logic [31:0] keys, diff;
  logic [3:0]  idx;
  logic [4:0]  sc;
  logic [9:0]  kc;
  logic        acc, is_load, idx_ok;

  assign keys = in_data_i[31:0];
  assign idx  = in_data_i[35:32];
  assign sc   = in_data_i[40:36];
  assign kc   = in_data_i[50:41];

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && !full_i;
  assign is_load    = (in_op_i == kce_pkg::OP_LOAD);
  assign idx_ok     = ({3'b000, idx} < DEPTH7);
  assign diff       = keys ^ prev_q;

  // drop out-of-range loads and scans with nothing changed
  assign push_o = acc && (is_load ? idx_ok : (diff != '0));

  always_comb begin
    push_data_o.kind = is_load ? kce_pkg::KIND_LOAD : kce_pkg::KIND_SCAN;
    push_data_o.keys = keys;
    push_data_o.diff = diff;
    push_data_o.idx  = idx;
    push_data_o.sc   = sc;
    push_data_o.kc   = kc;
  end

  assign prev_d = (acc && !is_load) ? keys : prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

// File: sv/kce_fifo.sv
module kce_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  kce_pkg::qent_t push_data_i,
  output logic           full_o,
  output logic           deq_valid_o,
  output kce_pkg::qent_t deq_data_o,
  input  logic           pop_i
);

  kce_pkg::qent_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign full_o      = (cnt_q == 2'd2);
  assign deq_valid_o = (cnt_q != 2'd0);
  assign deq_data_o  = mem_q[rp_q];
  assign pop         = pop_i && deq_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

endmodule

// File: sv/kce_back.sv
module kce_back #(
  parameter int unsigned KEYMAP_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           deq_valid_i,
  input  kce_pkg::qent_t deq_data_i,
  output logic           deq_pop_o,
  input  logic           cfg_we_i,
  input  logic [4:0]     keymap_count_i,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output kce_pkg::evt_t  m_data_o,
  output logic           m_last_o
);

  localparam int unsigned AW = (KEYMAP_DEPTH > 1) ? $clog2(KEYMAP_DEPTH) : 1;
  localparam int unsigned CW = $clog2(KEYMAP_DEPTH + 1);
  localparam logic [6:0] DEPTH7 = 7'(KEYMAP_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]    st_q, st_d;
  logic          dirty_q, dirty_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pend_q, pend_d;
  logic [31:0]   rem_q, rem_d;
  logic [31:0]   keys_q, keys_d;
  logic          any_q, any_d;
  logic [31:0]   lut_vld_q;
  logic [9:0]    lut_kc_q [32];
  logic          out_vld_q, out_vld_d;
  kce_pkg::evt_t out_evt_q, out_evt_d;
  logic          out_last_q, out_last_d;
  logic          lut_clr;

  logic [6:0]    cnt7, n7;
  logic [CW-1:0] n;
  logic          ram_we;
  logic [6:0]    widx7;
  logic [14:0]   ram_rdata;
  logic [4:0]    rd_sc;

  logic [31:0]   low, rest;
  logic [4:0]    sidx;
  logic          last, hit, out_free;
  kce_pkg::evt_t evt;

  // entries searched, saturated at the table depth
  assign cnt7 = {2'b00, keymap_count_i};
  assign n7   = (cnt7 > DEPTH7) ? DEPTH7 : cnt7;
  assign n    = n7[CW-1:0];

  assign ram_we = (st_q == ST_IDLE) && deq_valid_i && (deq_data_i.kind == kce_pkg::KIND_LOAD);
  assign widx7  = {3'b000, deq_data_i.idx};
  assign rd_sc  = ram_rdata[14:10];

  kce_ram #(
    .WIDTH(15),
    .DEPTH(KEYMAP_DEPTH)
  ) u_keymap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(widx7[AW-1:0]),
    .wdata_i({deq_data_i.sc, deq_data_i.kc}),
    .raddr_i(cnt_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // lowest pending changed bit
  assign low  = rem_q & (~rem_q + 32'd1);
  assign rest = rem_q & ~low;
  assign sidx = kce_pkg::onehot_idx(low);
  assign last = (rest == '0);
  assign hit  = lut_vld_q[sidx];

  always_comb begin
    evt.scancode = sidx;
    evt.keycode  = hit ? lut_kc_q[sidx] : 10'd0;
    evt.pressed  = keys_q[sidx];
    evt.mapped   = hit;
    evt.sync     = last && (any_q || hit);
  end

  assign out_free = !out_vld_q || m_ready_i;

  always_comb begin
    st_d       = st_q;
    dirty_d    = dirty_q | cfg_we_i;
    cnt_d      = cnt_q;
    pend_d     = 1'b0;
    rem_d      = rem_q;
    keys_d     = keys_q;
    any_d      = any_q;
    deq_pop_o  = 1'b0;
    lut_clr    = 1'b0;
    out_vld_d  = out_vld_q && !m_ready_i;
    out_evt_d  = out_evt_q;
    out_last_d = out_last_q;
    unique case (st_q)
      ST_IDLE: begin
        if (deq_valid_i) begin
          deq_pop_o = 1'b1;
          if (deq_data_i.kind == kce_pkg::KIND_LOAD) begin
            dirty_d = 1'b1;
          end else begin
            rem_d  = deq_data_i.diff;
            keys_d = deq_data_i.keys;
            any_d  = 1'b0;
            if (dirty_q) begin
              // rebuild scancode lookup from the keymap, last entry wins
              st_d    = ST_SWEEP;
              cnt_d   = '0;
              lut_clr = 1'b1;
              dirty_d = cfg_we_i;
            end else begin
              st_d = ST_EMIT;
            end
          end
        end
      end
      ST_SWEEP: begin
        if (cnt_q < n) begin
          cnt_d  = cnt_q + CW'(1);
          pend_d = 1'b1;
        end else if (!pend_q) begin
          st_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_evt_d  = evt;
          out_last_d = last;
          rem_d      = rest;
          any_d      = any_q | hit;
          if (last) begin
            st_d = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      dirty_q   <= 1'b1;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      rem_q     <= '0;
      any_q     <= 1'b0;
      out_vld_q <= 1'b0;
      lut_vld_q <= '0;
    end else begin
      st_q      <= st_d;
      dirty_q   <= dirty_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      rem_q     <= rem_d;
      any_q     <= any_d;
      out_vld_q <= out_vld_d;
      if (lut_clr) begin
        lut_vld_q <= '0;
      end else if (pend_q) begin
        lut_vld_q[rd_sc] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    keys_q     <= keys_d;
    out_evt_q  <= out_evt_d;
    out_last_q <= out_last_d;
    if (pend_q) begin
      lut_kc_q[rd_sc] <= ram_rdata[9:0];
    end
  end

  assign m_valid_o = out_vld_q;
  assign m_data_o  = out_evt_q;
  assign m_last_o  = out_last_q;

endmodule

// File: sv/key_change_event_encoder.sv
// Path: an accepted scan beat is queued in the FIFO, taken up by the back end from idle, and
//   its first event is registered at the output; a scan after a keymap load or keymap_count
//   write first rebuilds the scancode lookup, one keymap read per cycle over the entries searched.
// Throughput: one event per cycle while the output sink is ready.
//   A scan with no change and an ignored load produce no work.
// Reset: previous keys clear to all up, keymap_count to 0, queue and output empty.
`include "assert_macros.svh"

module key_change_event_encoder #(
  parameter int unsigned KEYMAP_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,     // keymap_count
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // key_bits[31:0], entry_index[35:32], entry_scancode[40:36], entry_keycode[50:41]
  input  logic [55:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,  // op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // scancode[4:0], keycode[14:5], pressed[15], mapped[16], sync[17]
  output logic [23:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  logic [4:0]     keymap_count_q;
  logic           fifo_full, fifo_push, deq_valid, deq_pop;
  kce_pkg::qent_t push_data, deq_data;
  kce_pkg::evt_t  m_evt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keymap_count_q <= '0;
    end else if (cfg_we_i) begin
      keymap_count_q <= cfg_wdata_i;
    end
  end

  kce_front #(
    .KEYMAP_DEPTH(KEYMAP_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_op_i    (s_axis_tuser_i),
    .in_data_i  (s_axis_tdata_i),
    .full_i     (fifo_full),
    .push_o     (fifo_push),
    .push_data_o(push_data)
  );

  kce_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fifo_push),
    .push_data_i(push_data),
    .full_o     (fifo_full),
    .deq_valid_o(deq_valid),
    .deq_data_o (deq_data),
    .pop_i      (deq_pop)
  );

  kce_back #(
    .KEYMAP_DEPTH(KEYMAP_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .deq_valid_i   (deq_valid),
    .deq_data_i    (deq_data),
    .deq_pop_o     (deq_pop),
    .cfg_we_i      (cfg_we_i),
    .keymap_count_i(keymap_count_q),
    .m_valid_o     (m_axis_tvalid_o),
    .m_ready_i     (m_axis_tready_i),
    .m_data_o      (m_evt),
    .m_last_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'b000000, m_evt};

  `ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, fifo_push && fifo_full)
  `ASSERT_IMPLY(a_sync_only_last, clk_i, rst_ni, m_axis_tvalid_o && m_evt.sync, m_axis_tlast_o)
  `ASSERT_IMPLY(a_unmapped_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_evt.mapped, m_evt.keycode == 10'd0)

endmodule

// File: test/testbench.sv
module testbench;

  localparam int unsigned KEYMAP_DEPTH  = 16;
  localparam int unsigned DRAIN_CYCLES  = 48;   // covers lookup rebuild plus pipeline
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS   = 25;
  localparam int unsigned IDLE_PCT      = 38;

  typedef struct {
    kce_pkg::evt_t ev;
    logic          last;
  } key_event_t;

  typedef struct {
    bit             wr_cfg;
    logic [4:0]     cfg_val;
    kce_pkg::kind_e op;
    logic [31:0]    keys;
    logic [3:0]     idx;
    logic [4:0]     sc;
    logic [9:0]     kc;
    bit             typed;
    key_event_t     want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic [55:0] s_tdata   = '0;
  logic        s_tuser   = 1'b0;
  logic        m_tready  = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [23:0] m_tdata;
  logic        m_tlast;

  // predictor state
  logic [31:0] prev_keys = '0;
  logic [4:0]  keymap_sc [KEYMAP_DEPTH];
  logic [9:0]  keymap_kc [KEYMAP_DEPTH];
  logic [4:0]  keymap_count = '0;
  key_event_t  pending_events [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          calm           = 1'b0;

  // sync, mapped, pressed are the top three bits of evt_t
  stim_row_t directed_rows [25] = '{
    '{0, 5'd0,  kce_pkg::KIND_SCAN, 32'h0000_0001, 4'd0,  5'd0,  10'd0,    1,
      '{{3'b001, 10'd0, 5'd0}, 1'b1}},
    '{0, 5'd0,  kce_pkg::KIND_SCAN, 32'h0000_0000, 4'd0,  5'd0,  10'd0,    1,
      '{{3'b000, 10'd0, 5'd0}, 1'b1}},
    '{0, 5'd0,  kce_pkg::KIND_SCAN, 32'h0000_0000, 4'd0,  5'd0,  10'd0,    0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_SCAN, 32'h8000_0000, 4'd0,  5'd0,  10'd0,    1,
      '{{3'b001, 10'd0, 5'd31}, 1'b1}},
    '{0, 5'd0,  kce_pkg::KIND_SCAN, 32'hFFFF_FFFF, 4'd0,  5'd0,  10'd0,    0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_SCAN, 32'h0000_0000, 4'd0,  5'd0,  10'd0,    0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_LOAD, 32'h5A5A_A5A5, 4'd0,  5'd0,  10'd1023, 0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_LOAD, 32'hA5A5_5A5A, 4'd1,  5'd31, 10'd0,    0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_LOAD, 32'h5A5A_A5A5, 4'd2,  5'd7,  10'd100,  0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_LOAD, 32'hA5A5_5A5A, 4'd3,  5'd3,  10'd555,  0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_LOAD, 32'h5A5A_A5A5, 4'd4,  5'd12, 10'd42,   0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_LOAD, 32'hA5A5_5A5A, 4'd5,  5'd7,  10'd200,  0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_LOAD, 32'h5A5A_A5A5, 4'd6,  5'd20, 10'd681,  0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_LOAD, 32'hA5A5_5A5A, 4'd7,  5'd31, 10'd512,  0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_LOAD, 32'h5A5A_A5A5, 4'd8,  5'd1,  10'd341,  0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_LOAD, 32'hA5A5_5A5A, 4'd9,  5'd16, 10'd1,    0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_LOAD, 32'h5A5A_A5A5, 4'd10, 5'd25, 10'd999,  0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_LOAD, 32'hA5A5_5A5A, 4'd11, 5'd9,  10'd256,  0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_LOAD, 32'h5A5A_A5A5, 4'd12, 5'd18, 10'd777,  0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_LOAD, 32'hA5A5_5A5A, 4'd13, 5'd0,  10'd5,    0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_LOAD, 32'h5A5A_A5A5, 4'd14, 5'd30, 10'd1000, 0, '{18'd0, 1'b0}},
    '{0, 5'd0,  kce_pkg::KIND_LOAD, 32'hA5A5_5A5A, 4'd15, 5'd15, 10'd682,  0, '{18'd0, 1'b0}},
    '{1, 5'd16, kce_pkg::KIND_SCAN, 32'hFFFF_FFFF, 4'd0,  5'd0,  10'd0,    0, '{18'd0, 1'b0}},
    // count above table depth saturates
    '{1, 5'd31, kce_pkg::KIND_SCAN, 32'h0000_0000, 4'd0,  5'd0,  10'd0,    0, '{18'd0, 1'b0}},
    // only slot 0 searched: scancode 0 maps to 1023
    '{1, 5'd1,  kce_pkg::KIND_SCAN, 32'h0000_0001, 4'd0,  5'd0,  10'd0,    1,
      '{{3'b111, 10'd1023, 5'd0}, 1'b1}}
  };

  key_change_event_encoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  // one event per changed bit, lowest first; last matching slot wins
  function automatic void predict_scan_events(input logic [31:0] keys, input bit emit);
    logic [31:0] diff;
    int unsigned active;
    key_event_t  e;
    key_event_t  run [$];
    bit          any_mapped;
    diff       = keys ^ prev_keys;
    active     = (keymap_count > KEYMAP_DEPTH) ? KEYMAP_DEPTH : keymap_count;
    any_mapped = 1'b0;
    for (int b = 0; b < 32; b++) begin
      if (diff[b]) begin
        e.ev          = '0;
        e.last        = 1'b0;
        e.ev.scancode = 5'(b);
        e.ev.pressed  = keys[b];
        for (int i = 0; i < active; i++) begin
          if (keymap_sc[i] == 5'(b)) begin
            e.ev.keycode = keymap_kc[i];
            e.ev.mapped  = 1'b1;
          end
        end
        any_mapped |= e.ev.mapped;
        run.push_back(e);
      end
    end
    if (run.size() > 0) begin
      run[run.size() - 1].ev.sync = any_mapped;
      run[run.size() - 1].last    = 1'b1;
    end
    if (emit) begin
      foreach (run[k]) pending_events.push_back(run[k]);
    end
    prev_keys = keys;
  endfunction

  task automatic send_item(input kce_pkg::kind_e op, input logic [31:0] keys,
                           input logic [3:0] idx, input logic [4:0] sc,
                           input logic [9:0] kc, input bit typed,
                           input key_event_t want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, kc, sc, idx, keys};
    s_tuser  <= op;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    if (op == kce_pkg::KIND_LOAD) begin
      if (idx < KEYMAP_DEPTH) begin
        keymap_sc[idx] = sc;
        keymap_kc[idx] = kc;
      end
    end else begin
      predict_scan_events(keys, !typed);
      if (typed) pending_events.push_back(want);
    end
  endtask

  // only while idle: loads leave no events behind, so wait out the pipeline too
  task automatic write_keymap_count(input logic [4:0] value);
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we       <= 1'b0;
    keymap_count  = value;
  endtask

  // output beat checker and sink backpressure
  always @(posedge clk_i) begin
    key_event_t    want;
    kce_pkg::evt_t got;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event beat tdata=%h", m_tdata));
      end else begin
        want = pending_events.pop_front();
        got  = kce_pkg::evt_t'(m_tdata[17:0]);
        check_field("scancode", got.scancode, want.ev.scancode);
        check_field("keycode",  got.keycode,  want.ev.keycode);
        check_field("pressed",  got.pressed,  want.ev.pressed);
        check_field("mapped",   got.mapped,   want.ev.mapped);
        check_field("sync",     got.sync,     want.ev.sync);
        check_field("last",     m_tlast,      want.last);
      end
    end
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [4:0]  count_val;
    logic [31:0] keys;
    logic [31:0] mask;
    int unsigned pick;
    key_event_t  none;
    none = '{18'd0, 1'b0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].wr_cfg) write_keymap_count(directed_rows[r].cfg_val);
      send_item(directed_rows[r].op, directed_rows[r].keys, directed_rows[r].idx,
                directed_rows[r].sc, directed_rows[r].kc, directed_rows[r].typed,
                directed_rows[r].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = (p == 4 || p == 5);
      case (p)
        0:       count_val = 5'd0;
        1:       count_val = 5'd16;
        default: count_val = ($urandom_range(99) < 15) ? 5'($urandom_range(31, 17))
                                                      : 5'($urandom_range(16, 0));
      endcase
      write_keymap_count(count_val);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          send_item(kce_pkg::KIND_LOAD, $urandom, 4'($urandom_range(15)),
                    5'($urandom_range(31)), 10'($urandom_range(1023)), 1'b0, none);
        end else begin
          pick = $urandom_range(99);
          if (pick < 40) begin
            mask = '0;
            repeat ($urandom_range(3, 1)) mask[$urandom_range(31)] = 1'b1;
            keys = prev_keys ^ mask;
          end else if (pick < 60) begin
            keys = $urandom;
          end else if (pick < 70) begin
            keys = prev_keys;
          end else if (pick < 80) begin
            keys = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
          end else begin
            keys = prev_keys ^ (32'h1 << $urandom_range(31));
          end
          send_item(kce_pkg::KIND_SCAN, keys, 4'($urandom_range(15)),
                    5'($urandom_range(31)), 10'($urandom_range(1023)), 1'b0, none);
        end
      end
    end

    calm = 1'b0;
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
